// File: hw/rtl/bmp_dec_pkg.sv
// Package for the BMP pixel stream decoder: word types, status codes,
// parse phases, header byte offsets and size bounds. Used by bmp_pixel_stream_decoder and its bench.
`timescale 1ns / 1ps
package bmp_dec_pkg;

  localparam int unsigned MaxWidth     = 4096;
  localparam int unsigned MaxHeight    = 4096;
  localparam int unsigned PaletteDepth = 256;
  localparam int unsigned HdrLastByte  = 53;
  localparam int unsigned HdrMagicByte = 1;
  localparam int unsigned HdrWidthByte = 21;
  localparam int unsigned HdrHeightByte = 29 - 4;
  localparam int unsigned HdrDepthByte = 29;
  localparam int unsigned HdrPalByte   = 49;
  localparam logic [15:0] Magic        = 16'h4D42;

  typedef enum logic [1:0] {
    StPixel    = 2'd0,
    StBadMagic = 2'd1,
    StBadDepth = 2'd2,
    StBounds   = 2'd3
  } status_e;

  typedef enum logic [4:0] {
    PhHeader  = 5'b00001,
    PhPalette = 5'b00010,
    PhPixels  = 5'b00100,
    PhDone    = 5'b01000,
    PhHalt    = 5'b10000
  } phase_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       start_of_file;
  } in_word_t;

  typedef struct packed {
    logic [11:0] pixel_x;
    logic [11:0] pixel_y;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [7:0]  palette_index;
    logic [1:0]  status;
    logic        last_of_run;
    logic        last_of_image;
  } out_word_t;

endpackage

// File: hw/rtl/bmp_pixel_stream_decoder.sv
// BMP pixel stream decoder top level: header parser, palette store and
// pixel unpacker with a registered output word. Depends on bmp_dec_pkg.
//
//   channel  direction  handshake               word
//   in       input      in_valid_i/in_ready_o   in_word_t
//   out      output     out_valid_o/out_ready_i out_word_t
//   cfg      input      cfg_valid_i/cfg_ready_o indexed_mode bit
//
// An input word is held until every result it causes has been loaded into the
// output register, which takes one pixel per cycle unless out_ready_i stalls it;
// a 1 bpp byte gives up to eight pixels. The palette is read at the output register load.
// Reset clears all control state; no clearing pass is needed.
// A stalled output holds the input stage, which holds in_ready_o low.
`timescale 1ns / 1ps
module bmp_pixel_stream_decoder import bmp_dec_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_word_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_word_t out_data_o,
  input  logic      cfg_valid_i,
  output logic      cfg_ready_o,
  input  logic      cfg_data_i
);

  logic        hold_valid_q;
  in_word_t    hold_q;
  logic        indexed_q;
  phase_e      phase_q, phase_d;
  logic [5:0]  hcount_q, hcount_d;
  logic [31:0] shift_q, shift_d;
  logic [12:0] width_q, width_d, height_q, height_d;
  logic [5:0]  bpp_q, bpp_d;
  logic [8:0]  pcount_q, pcount_d;
  logic [9:0]  pbc_q, pbc_d;
  logic [12:0] col_q, col_d, row_q, row_d;
  logic [14:0] line_q, line_d;
  logic [23:0] partial_q, partial_d;
  logic [1:0]  kbyte_q, kbyte_d;
  logic [2:0]  sel_q, sel_d;
  logic [23:0] pal_mem [PaletteDepth];
  logic [23:0] pal_rd_q;

  logic        out_valid_q;
  logic [11:0] ox_q, oy_q;
  logic [23:0] orgb_q;
  logic [7:0]  oidx_q;
  status_e     ost_q;
  logic        olast_run_q, olast_img_q, ouse_pal_q;

  logic        can_emit, step, final_c, emit, pal_wr;
  logic [11:0] ex, ey;
  logic [23:0] ergb;
  logic [7:0]  eidx;
  status_e     est;
  logic        elast_run, elast_img, euse_pal;
  phase_e      ph_eff;
  logic [5:0]  hc_eff;
  logic [31:0] v;
  logic [15:0] v_hi;
  logic [7:0]  b;
  logic        idx_depth;
  logic [9:0]  np;
  logic [14:0] raw, row_bytes, data_bytes, line_nx;
  logic [10:0] pbc_nx;
  logic [12:0] col_nx;

  assign can_emit    = !out_valid_q || out_ready_i;
  assign step        = hold_valid_q && can_emit;
  assign in_ready_o  = !hold_valid_q || (step && final_c);
  assign cfg_ready_o = 1'b1;
  assign b           = hold_q.data_byte;
  assign ph_eff      = hold_q.start_of_file ? PhHeader : phase_q;
  assign hc_eff      = hold_q.start_of_file ? 6'd0 : hcount_q;
  assign v           = {b, (hold_q.start_of_file ? 24'd0 : shift_q[31:8])};
  assign v_hi        = v[31:16];
  assign idx_depth   = (bpp_q == 6'd1) || (bpp_q == 6'd4) || (bpp_q == 6'd8);
  assign np          = (pcount_q == 9'd0) ? (10'd1 << bpp_q) : {1'b0, pcount_q};
  assign pbc_nx      = {1'b0, pbc_q} + 11'd1;
  assign line_nx     = line_q + 15'd1;
  assign col_nx      = col_q + 13'd1;

  always_comb begin
    case (bpp_q)
      6'd1:    raw = {5'd0, width_q[12:3] + 10'(width_q[2:0] != 3'd0)};
      6'd4:    raw = {2'd0, 1'b0, width_q[12:1] + 12'(width_q[0])};
      6'd8:    raw = {2'd0, width_q};
      6'd24:   raw = {2'd0, width_q} + {1'b0, width_q, 1'b0};
      default: raw = {width_q, 2'b00};
    endcase
    row_bytes  = (raw + 15'd3) & ~15'd3;
    data_bytes = (bpp_q == 6'd24) ? ({2'd0, width_q} + {1'b0, width_q, 1'b0})
                                  : {width_q, 2'b00};
  end

  always_comb begin
    phase_d = phase_q; hcount_d = hcount_q; shift_d = shift_q;
    width_d = width_q; height_d = height_q; bpp_d = bpp_q;
    pcount_d = pcount_q; pbc_d = pbc_q; col_d = col_q; row_d = row_q;
    line_d = line_q; partial_d = partial_q; kbyte_d = kbyte_q; sel_d = sel_q;
    final_c = 1'b1; emit = 1'b0; pal_wr = 1'b0;
    ex = 12'd0; ey = 12'd0; ergb = 24'd0; eidx = 8'd0; est = StPixel;
    elast_run = 1'b1; elast_img = 1'b0; euse_pal = 1'b0;
    case (ph_eff)
      PhHeader: begin
        phase_d = PhHeader;
        shift_d = v;
        hcount_d = hc_eff + 6'd1;
        if (hc_eff == 6'(HdrMagicByte) && v_hi != Magic) begin
          emit = 1'b1; est = StBadMagic; phase_d = PhHalt; hcount_d = 6'd0;
        end else begin
          if (hc_eff == 6'(HdrWidthByte))
            width_d = (v >= 32'd1 && v <= 32'(MaxWidth)) ? v[12:0] : 13'd0;
          if (hc_eff == 6'(HdrHeightByte))
            height_d = (v >= 32'd1 && v <= 32'(MaxHeight)) ? v[12:0] : 13'd0;
          if (hc_eff == 6'(HdrDepthByte))
            bpp_d = (v_hi == 16'd1 || v_hi == 16'd4 || v_hi == 16'd8 ||
                     v_hi == 16'd24 || v_hi == 16'd32) ? v_hi[5:0] : 6'd0;
          if (hc_eff == 6'(HdrPalByte))
            pcount_d = (v > 32'd256) ? 9'd257 : v[8:0];
          if (hc_eff >= 6'(HdrLastByte)) begin
            col_d = 13'd0; row_d = 13'd0; line_d = 15'd0; partial_d = 24'd0;
            pbc_d = 10'd0; hcount_d = 6'd0; kbyte_d = 2'd0; sel_d = 3'd0;
            if (bpp_q == 6'd0 || (indexed_q && !idx_depth)) begin
              emit = 1'b1; est = StBadDepth; phase_d = PhHalt;
            end else if (width_q == 13'd0 || height_q == 13'd0) begin
              emit = 1'b1; est = StBounds; phase_d = PhHalt;
            end else if (idx_depth) begin
              if (np > 10'(PaletteDepth)) begin
                emit = 1'b1; est = StBounds; phase_d = PhHalt;
              end else begin
                pcount_d = np[8:0]; phase_d = PhPalette;
              end
            end else begin
              phase_d = PhPixels;
            end
          end
        end
      end
      PhPalette: begin
        case (pbc_q[1:0])
          2'd0: partial_d = {16'd0, b};
          2'd1: partial_d = {partial_q[23:16], b, partial_q[7:0]};
          2'd2: begin
            partial_d = {b, partial_q[15:0]};
            pal_wr = 1'b1;
          end
          default: partial_d = partial_q;
        endcase
        pbc_d = pbc_nx[9:0];
        if (pbc_nx >= {pcount_q, 2'b00}) begin
          pbc_d = 10'd0; partial_d = 24'd0; phase_d = PhPixels;
        end
      end
      PhPixels: begin
        ex = col_q[11:0];
        ey = 12'(height_q - 13'd1 - row_q);
        elast_img = (col_nx == width_q) && (row_q + 13'd1 == height_q);
        if (idx_depth) begin
          euse_pal = 1'b1;
          emit = col_q < width_q;
          case (bpp_q)
            6'd1: begin
              eidx = {7'd0, b[3'd7 - sel_q]};
              elast_run = (sel_q == 3'd7) || (col_nx >= width_q);
            end
            6'd4: begin
              eidx = {4'd0, (sel_q[0] ? b[3:0] : b[7:4])};
              elast_run = sel_q[0] || (col_nx >= width_q);
            end
            default: eidx = b;
          endcase
          final_c = !emit || elast_run;
          if (emit) col_d = col_nx;
          sel_d = final_c ? 3'd0 : sel_q + 3'd1;
        end else begin
          ergb = partial_q;
          if (line_q < data_bytes) begin
            kbyte_d = (kbyte_q == ((bpp_q == 6'd24) ? 2'd2 : 2'd3)) ? 2'd0
                                                                      : kbyte_q + 2'd1;
            case (kbyte_q)
              2'd0: partial_d = {16'd0, b};
              2'd1: partial_d = {partial_q[23:16], b, partial_q[7:0]};
              2'd2: begin
                partial_d = {b, partial_q[15:0]};
                ergb = partial_d;
                emit = col_q < width_q;
                if (emit) col_d = col_nx;
              end
              default: partial_d = partial_q;
            endcase
          end
        end
        if (final_c) begin
          line_d = line_nx;
          if (line_nx >= row_bytes) begin
            line_d = 15'd0; col_d = 13'd0; kbyte_d = 2'd0;
            row_d = row_q + 13'd1;
            if (row_q + 13'd1 >= height_q) phase_d = PhDone;
          end
        end
      end
      default: phase_d = ph_eff;
    endcase
    if (est != StPixel) begin
      elast_run = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_valid_q <= 1'b0;
      indexed_q <= 1'b0;
      phase_q <= PhHeader; hcount_q <= '0; shift_q <= '0;
      width_q <= '0; height_q <= '0; bpp_q <= '0; pcount_q <= '0;
      pbc_q <= '0; col_q <= '0; row_q <= '0; line_q <= '0;
      partial_q <= '0; kbyte_q <= '0; sel_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) indexed_q <= cfg_data_i;
      if (in_ready_o) hold_valid_q <= in_valid_i;
      if (step) begin
        phase_q <= phase_d; hcount_q <= hcount_d; shift_q <= shift_d;
        width_q <= width_d; height_q <= height_d; bpp_q <= bpp_d;
        pcount_q <= pcount_d; pbc_q <= pbc_d; col_q <= col_d; row_q <= row_d;
        line_q <= line_d; partial_q <= partial_d; kbyte_q <= kbyte_d;
        sel_q <= sel_d;
      end
      if (can_emit) out_valid_q <= step && emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) hold_q <= in_data_i;
    if (step && emit) begin
      ox_q <= ex; oy_q <= ey; orgb_q <= ergb; oidx_q <= eidx; ost_q <= est;
      olast_run_q <= elast_run; olast_img_q <= elast_img; ouse_pal_q <= euse_pal;
      pal_rd_q <= pal_mem[eidx];
    end
    if (step && pal_wr) pal_mem[pbc_q[9:2]] <= partial_d;
  end

  logic [23:0] rgb_out;
  assign rgb_out     = ouse_pal_q ? pal_rd_q : orgb_q;
  assign out_valid_o = out_valid_q;
  always_comb begin
    out_data_o.pixel_x       = ox_q;
    out_data_o.pixel_y       = oy_q;
    out_data_o.red           = rgb_out[23:16];
    out_data_o.green         = rgb_out[15:8];
    out_data_o.blue          = rgb_out[7:0];
    out_data_o.palette_index = oidx_q;
    out_data_o.status        = ost_q;
    out_data_o.last_of_run   = olast_run_q;
    out_data_o.last_of_image = olast_img_q;
  end

endmodule

// File: bench/bmp_pixel_stream_decoder_tb.sv
// Self-checking bench for bmp_pixel_stream_decoder: sends BMP files, some
// truncated, byte by byte, predicts every pixel and error word, and compares them.
// Depends on bmp_dec_pkg and the decoder RTL.
`timescale 1ns / 1ps
module bmp_pixel_stream_decoder_tb;
  import bmp_dec_pkg::*;

  localparam int unsigned DrainCycles = 24;
  localparam int unsigned QuietLimit  = 6000;
  localparam int unsigned RandBytes   = 60;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid_i = 1'b0;
  logic      in_ready_o;
  in_word_t  in_data_i = '0;
  logic      out_valid_o;
  logic      out_ready_i = 1'b0;
  out_word_t out_data_o;
  logic      cfg_valid_i = 1'b0;
  logic      cfg_ready_o;
  logic      cfg_data_i = 1'b0;

  bmp_pixel_stream_decoder u_dut (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .in_data_i,
    .out_valid_o, .out_ready_i, .out_data_o,
    .cfg_valid_i, .cfg_ready_o, .cfg_data_i
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Decoder state as the bench sees it.
  bit          mode_q;
  phase_e      phase_q;
  int unsigned hdr_cnt, shift_q, width_q, height_q, depth_q, pal_cnt;
  logic [23:0] pal_mem [PaletteDepth];
  int unsigned pal_bytes, col_q, row_q, line_q, part_q;

  out_word_t   pixel_q [$];
  out_word_t   step_buf [$];
  logic [7:0]  file_q [$];
  int unsigned errors, bytes_sent, words_seen, files_sent, err_words;
  int unsigned quiet;
  bit          hold_req;

  task automatic report(string what, int unsigned got, int unsigned want);
    $display("mismatch at %0t: %s got %0d expected %0d", $time, what, got, want);
    errors++;
  endtask

  function automatic void push_word(int unsigned x, int unsigned y, int unsigned rgb,
                                    int unsigned idx, status_e st, bit last_img);
    out_word_t w;
    w.pixel_x = x[11:0];
    w.pixel_y = y[11:0];
    w.red = rgb[23:16];
    w.green = rgb[15:8];
    w.blue = rgb[7:0];
    w.palette_index = idx[7:0];
    w.status = st;
    w.last_of_run = 1'b0;
    w.last_of_image = last_img;
    step_buf.push_back(w);
  endfunction

  function automatic void push_pixel(int unsigned rgb, int unsigned idx);
    push_word(col_q, height_q - 1 - row_q, rgb, idx, StPixel,
              col_q + 1 == width_q && row_q + 1 == height_q);
    col_q++;
  endfunction

  function automatic void push_index(int unsigned idx);
    if (col_q < width_q) push_pixel(pal_mem[idx[7:0]], idx);
  endfunction

  function automatic bit is_pal_depth(int unsigned b);
    return b == 1 || b == 4 || b == 8;
  endfunction

  function automatic int unsigned row_len();
    int unsigned raw;
    case (depth_q)
      1: raw = (width_q + 7) >> 3;
      4: raw = (width_q + 1) >> 1;
      8: raw = width_q;
      24: raw = width_q * 3;
      default: raw = width_q * 4;
    endcase
    return (raw + 3) & ~32'd3;
  endfunction

  function automatic void end_header();
    int unsigned np;
    col_q = 0; row_q = 0; line_q = 0; part_q = 0; pal_bytes = 0; hdr_cnt = 0;
    np = pal_cnt != 0 ? pal_cnt : (1 << depth_q);
    if (depth_q == 0 || (mode_q && !is_pal_depth(depth_q))) begin
      push_word(0, 0, 0, 0, StBadDepth, 0);
      phase_q = PhHalt;
    end else if (width_q == 0 || height_q == 0 ||
                 (is_pal_depth(depth_q) && np > PaletteDepth)) begin
      push_word(0, 0, 0, 0, StBounds, 0);
      phase_q = PhHalt;
    end else if (is_pal_depth(depth_q)) begin
      pal_cnt = np;
      phase_q = PhPalette;
    end else begin
      phase_q = PhPixels;
    end
  endfunction

  function automatic void decode_byte(logic [7:0] b, logic sof);
    int unsigned v, k, sz;
    step_buf.delete();
    if (sof) begin
      phase_q = PhHeader; hdr_cnt = 0; shift_q = 0;
    end
    case (phase_q)
      PhHeader: begin
        shift_q = (shift_q >> 8) | (int'(b) << 24);
        v = shift_q;
        if (hdr_cnt == HdrMagicByte && v[31:16] != Magic) begin
          push_word(0, 0, 0, 0, StBadMagic, 0);
          phase_q = PhHalt;
          hdr_cnt = 0;
        end else if (hdr_cnt == HdrWidthByte) begin
          width_q = (v >= 1 && v <= MaxWidth) ? v : 0;
        end else if (hdr_cnt == HdrHeightByte) begin
          height_q = (v >= 1 && v <= MaxHeight) ? v : 0;
        end else if (hdr_cnt == HdrDepthByte) begin
          v = v >> 16;
          depth_q = (is_pal_depth(v) || v == 24 || v == 32) ? v : 0;
        end else if (hdr_cnt == HdrPalByte) begin
          pal_cnt = v > 256 ? 257 : v;
        end
        if (phase_q == PhHeader) begin
          if (hdr_cnt >= HdrLastByte) end_header();
          else hdr_cnt++;
        end
      end
      PhPalette: begin
        k = pal_bytes & 3;
        if (k == 0) part_q = b;
        else if (k == 1) part_q |= int'(b) << 8;
        else if (k == 2) begin
          part_q |= int'(b) << 16;
          if ((pal_bytes >> 2) < PaletteDepth) pal_mem[pal_bytes >> 2] = part_q[23:0];
        end
        pal_bytes++;
        if (pal_bytes >= 4 * pal_cnt) begin
          pal_bytes = 0; part_q = 0; phase_q = PhPixels;
        end
      end
      PhPixels: begin
        if (depth_q == 1) begin
          for (int s = 7; s >= 0; s--) push_index(b[s]);
        end else if (depth_q == 4) begin
          push_index(b[7:4]);
          push_index(b[3:0]);
        end else if (depth_q == 8) begin
          push_index(b);
        end else begin
          sz = depth_q >> 3;
          if (line_q < sz * width_q) begin
            k = line_q % sz;
            if (k == 0) part_q = b;
            else if (k == 1) part_q |= int'(b) << 8;
            else if (k == 2) begin
              part_q |= int'(b) << 16;
              if (col_q < width_q) push_pixel(part_q & 32'hFFFFFF, 0);
            end
          end
        end
        line_q++;
        if (line_q >= row_len()) begin
          line_q = 0; col_q = 0; row_q++;
          if (row_q >= height_q) phase_q = PhDone;
        end
      end
      default: ;
    endcase
    if (step_buf.size() > 0) step_buf[$].last_of_run = 1'b1;
    foreach (step_buf[i]) pixel_q.push_back(step_buf[i]);
  endfunction

  task automatic send_byte(logic [7:0] b, logic sof);
    int unsigned gap;
    gap = ($urandom_range(0, 9) < 6) ? 0 :
          ($urandom_range(0, 19) == 0 ? $urandom_range(10, 40) : $urandom_range(1, 3));
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= '{data_byte: b, start_of_file: sof};
    do @(posedge clk_i); while (!in_ready_o);
    decode_byte(b, sof);
    bytes_sent++;
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (pixel_q.size() > 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_mode(bit m);
    drain();
    cfg_valid_i <= 1'b1;
    cfg_data_i <= m;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    mode_q = m;
  endtask

  function automatic void put32(int unsigned v);
    for (int i = 0; i < 4; i++) file_q.push_back(v[8*i +: 8]);
  endfunction

  // Builds a file in file_q; the body follows only a header that can be valid.
  // Pixel indices stay below the file's own palette count.
  function automatic void build_file(logic [15:0] magic, int unsigned w, int unsigned h,
                                     int unsigned bpp, int unsigned pal);
    int unsigned np, rl, raw;
    bit          body_ok;
    logic [7:0]  pix;
    file_q.delete();
    file_q.push_back(magic[7:0]);
    file_q.push_back(magic[15:8]);
    put32($urandom); put32(0); put32(54); put32(40); put32(w); put32(h);
    put32({bpp[15:0], 16'd1});
    for (int i = 0; i < 4; i++) put32($urandom);
    put32(pal); put32($urandom);
    np = pal != 0 ? pal : (1 << bpp);
    body_ok = magic == Magic && w >= 1 && w <= MaxWidth && h >= 1 && h <= MaxHeight &&
              ((is_pal_depth(bpp) && np <= PaletteDepth) || bpp == 24 || bpp == 32);
    if (body_ok && is_pal_depth(bpp))
      for (int i = 0; i < 4 * np; i++) file_q.push_back(8'($urandom));
    if (body_ok) begin
      raw = bpp == 1 ? (w + 7) / 8 : bpp == 4 ? (w + 1) / 2 : w * ((bpp + 7) / 8);
      rl = (raw + 3) & ~32'd3;
      for (int i = 0; i < rl * h; i++) begin
        pix = 8'($urandom);
        if (bpp == 8) pix = 8'($urandom_range(0, np - 1));
        else if (bpp == 4)
          pix = {4'($urandom_range(0, np - 1)), 4'($urandom_range(0, np - 1))};
        else if (bpp == 1 && np < 2) pix = 8'd0;
        file_q.push_back(pix);
      end
    end
    for (int i = $urandom_range(0, 3); i > 0; i--) file_q.push_back(8'($urandom));
  endfunction

  task automatic send_file(bit mark_first);
    foreach (file_q[i]) send_byte(file_q[i], i == 0 ? mark_first : ($urandom_range(0, 199) == 0));
    files_sent++;
  endtask

  typedef struct {
    logic [15:0] magic;
    int unsigned w, h, bpp, pal;
    bit          mode, is_err;
    status_e     st;
  } file_case_t;

  file_case_t dir_tab [] = '{
    '{16'h4142, 4, 2, 8, 2, 0, 1, StBadMagic},
    '{Magic, 9, 2, 1, 0, 0, 0, StPixel},
    '{Magic, 5, 2, 4, 3, 0, 0, StPixel},
    '{Magic, 3, 1, 8, 4, 0, 0, StPixel},
    '{Magic, 2, 1, 24, 999, 0, 0, StPixel},
    '{Magic, 2, 2, 32, 0, 1, 1, StBadDepth},
    '{Magic, 4097, 2, 24, 0, 0, 1, StBounds}
  };

  always @(posedge clk_i) begin
    int unsigned hold_left, stall_left;
    if (out_valid_o && out_ready_i) begin
      words_seen++;
      if (pixel_q.size() == 0) begin
        report("unexpected word, status", out_data_o.status, 0);
      end else begin
        out_word_t e;
        e = pixel_q.pop_front();
        if (out_data_o.status != StPixel) err_words++;
        if (out_data_o.pixel_x !== e.pixel_x) report("pixel_x", out_data_o.pixel_x, e.pixel_x);
        if (out_data_o.pixel_y !== e.pixel_y) report("pixel_y", out_data_o.pixel_y, e.pixel_y);
        if (out_data_o.red !== e.red) report("red", out_data_o.red, e.red);
        if (out_data_o.green !== e.green) report("green", out_data_o.green, e.green);
        if (out_data_o.blue !== e.blue) report("blue", out_data_o.blue, e.blue);
        if (out_data_o.palette_index !== e.palette_index)
          report("palette_index", out_data_o.palette_index, e.palette_index);
        if (out_data_o.status !== e.status) report("status", out_data_o.status, e.status);
        if (out_data_o.last_of_run !== e.last_of_run)
          report("last_of_run", out_data_o.last_of_run, e.last_of_run);
        if (out_data_o.last_of_image !== e.last_of_image)
          report("last_of_image", out_data_o.last_of_image, e.last_of_image);
      end
    end
    if (hold_req) begin
      hold_req = 1'b0;
      hold_left = 400;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_ready_i <= 1'b0;
    end else if ($urandom_range(0, 9) < 3) begin
      stall_left = ($urandom_range(0, 19) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 3);
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet = 0;
    end else if (++quiet >= QuietLimit) begin
      $display("bmp_pixel_stream_decoder regression: fail");
      $finish;
    end
  end

  initial begin
    int unsigned start_bytes, bpp, w, pal;
    int unsigned depths [5] = '{1, 4, 8, 24, 32};
    mode_q = 1'b0;
    phase_q = PhHeader;
    {hdr_cnt, shift_q, width_q, height_q, depth_q, pal_cnt} = '0;
    {pal_bytes, col_q, row_q, line_q, part_q} = '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_tab[i]) begin
      if (dir_tab[i].mode != mode_q) write_mode(dir_tab[i].mode);
      build_file(dir_tab[i].magic, dir_tab[i].w, dir_tab[i].h, dir_tab[i].bpp,
                 dir_tab[i].pal);
      if (i == 1) hold_req = 1'b1;
      send_file(i != 0);
      if (dir_tab[i].is_err) begin
        drain();
        if (err_words == 0 || pixel_q.size() != 0)
          report("error word count", err_words, 1);
        err_words = 0;
      end
    end
    drain();

    start_bytes = bytes_sent;
    while (bytes_sent - start_bytes < RandBytes) begin
      if ($urandom_range(0, 5) == 0) write_mode($urandom_range(0, 1));
      if ($urandom_range(0, 7) == 0) drain();
      bpp = depths[$urandom_range(0, 4)];
      w = $urandom_range(1, 12);
      pal = (bpp == 8) ? $urandom_range(1, 6) :
            (bpp < 24 && $urandom_range(0, 1) == 0) ? $urandom_range(1, 1 << bpp) : 0;
      case ($urandom_range(0, 11))
        0: build_file($urandom, w, 2, bpp, pal);
        1: build_file(Magic, w, 2, $urandom_range(0, 40), $urandom_range(1, 2));
        2: build_file(Magic, $urandom_range(0, 1) ? 0 : $urandom, 2, bpp, pal);
        3: build_file(Magic, w, 2, bpp, $urandom_range(257, 600));
        default: build_file(Magic, w, $urandom_range(1, 3), bpp, pal);
      endcase
      if ($urandom_range(0, 7) == 0) file_q = file_q[0 : $urandom_range(1, file_q.size() - 1)];
      send_file(1'b1);
    end

    drain();
    $display("Ran %0d files, %0d bytes and %0d output words, both modes,",
             files_sent, bytes_sent, words_seen);
    $display("covering pixel files, header errors, truncated files and stalls.");
    if (errors == 0 && pixel_q.size() == 0) begin
      $display("bmp_pixel_stream_decoder regression: pass");
    end else begin
      $display("%0d mismatches, %0d words never seen", errors, pixel_q.size());
      $display("bmp_pixel_stream_decoder regression: fail");
    end
    $finish;
  end

endmodule
